@@ design/dsm_pkg.sv @@
// Shared types and constants for the dot-star pattern matcher.
// No dependencies; used by dsm_cell_unit and dot_star_pattern_matcher_core.
package dsm_pkg;

   localparam int DEFAULT_MAX_PATTERN = 32;

   localparam logic [7:0] CHAR_STAR = 8'h2A;
   localparam logic [7:0] CHAR_DOT  = 8'h2E;
   localparam logic [7:0] CHAR_A    = 8'h61;
   localparam logic [7:0] CHAR_Z    = 8'h7A;

   typedef enum logic [1:0] {
      KIND_CLEAR  = 2'd0,
      KIND_APPEND = 2'd1,
      KIND_TEXT   = 2'd2,
      KIND_END    = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] symbol;
   } req_type;

   typedef struct packed {
      logic matched;
      logic pattern_overflow;
   } rsp_type;

   // Operands of one evaluation of the match recurrence at pattern position j.
   typedef struct packed {
      logic [7:0] pat_char;    // pattern character j-1
      logic [7:0] prev_char;   // pattern character j-2
      logic [7:0] text_char;
      logic       first_pos;   // j == 1
      logic       old_jm1;     // previous row, bit j-1
      logic       old_j;       // previous row, bit j
      logic       new_jm2;     // new row, bit j-2
   } cell_in_type;

endpackage

@@ design/dsm_cell_unit.sv @@
// Evaluates one position of the dot-star match recurrence.
// Depends on dsm_pkg for the operand struct and character constants.
module dsm_cell_unit (
   input  dsm_pkg::cell_in_type cell_in,
   output logic                 next_bit
);

   logic pat_letter;
   logic prev_elem_match;

   always_comb begin
      pat_letter = cell_in.pat_char inside {[dsm_pkg::CHAR_A:dsm_pkg::CHAR_Z]};
      prev_elem_match = (cell_in.prev_char == dsm_pkg::CHAR_DOT) ||
                        ((cell_in.prev_char inside {[dsm_pkg::CHAR_A:dsm_pkg::CHAR_Z]}) &&
                         (cell_in.prev_char == cell_in.text_char));
      if (cell_in.pat_char == dsm_pkg::CHAR_DOT) begin
         next_bit = cell_in.old_jm1;
      end else if (pat_letter) begin
         next_bit = (cell_in.pat_char == cell_in.text_char) && cell_in.old_jm1;
      end else if ((cell_in.pat_char == dsm_pkg::CHAR_STAR) && !cell_in.first_pos) begin
         next_bit = cell_in.new_jm2 || (cell_in.old_j && prev_elem_match);
      end else begin
         next_bit = 1'b0;
      end
   end

endmodule

@@ design/dot_star_pattern_matcher_core.sv @@
// Top level of the dot-star pattern matcher: sequencer, pattern memory and match rows.
// Depends on dsm_pkg and dsm_cell_unit.
//
//   channel | direction | payload         | handshake
//   req     | in        | dsm_pkg::req_type | req_valid / req_ready
//   rsp     | out       | dsm_pkg::rsp_type | rsp_valid / rsp_ready
//
// Clear, append and end-of-text transfers are handled in the idle state. A text
// character starts a sweep over positions 1..L, L being the stored pattern length
// (at most MAX_PATTERN), with no request taken: the single evaluation unit visits one
// pattern position per cycle, fed by the pattern memory's one registered read port.
// Reset is synchronous and leaves an empty pattern; no clearing pass is needed.
// Requests are taken whenever idle, end-of-text only if no result waits on rsp_ready.
module dot_star_pattern_matcher_core #(
   parameter int MAX_PATTERN = dsm_pkg::DEFAULT_MAX_PATTERN
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dsm_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dsm_pkg::rsp_type rsp_payload
);

   localparam int ROW = MAX_PATTERN + 1;
   localparam int LW  = $clog2(MAX_PATTERN + 1);
   localparam int AW  = $clog2(MAX_PATTERN);

   typedef enum logic {ST_IDLE, ST_SWEEP} state_type;

   // Sequencer and row state.
   state_type        state_ff, state_in;
   logic [LW-1:0]    pos_ff, pos_in;          // pattern position being evaluated
   logic [LW-1:0]    len_ff, len_in;
   logic             ovf_ff, ovf_in;
   logic [ROW-1:0]   empty_ff, empty_in;      // match row for the empty text
   logic [ROW-1:0]   row_ff, row_in;          // match row for the text so far
   logic             old_prev_ff, old_prev_in; // old row bit j-1, saved before overwrite
   logic             new1_ff, new1_in;        // new row bit j-1
   logic             new2_ff, new2_in;        // new row bit j-2
   logic [7:0]       prev_char_ff, prev_char_in;
   logic [7:0]       sym_ff, sym_in;
   logic             rsp_valid_ff, rsp_valid_in;
   dsm_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // Pattern memory with a registered read port.
   logic [7:0]       pattern_mem [MAX_PATTERN];
   logic [7:0]       rd_data_ff;
   logic [AW-1:0]    rd_addr;
   logic             mem_we;

   logic             req_fire;
   logic [LW-1:0]    len_plus;
   dsm_pkg::cell_in_type cell_in;
   logic             cell_next;

   assign req_ready = (state_ff == ST_IDLE) &&
                      ((req_payload.kind != dsm_pkg::KIND_END) || !rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign len_plus  = len_ff + LW'(1);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // While idle the memory keeps position zero ready, so a text transfer finds
   // the first pattern character registered when the sweep starts.
   assign rd_addr = (state_ff == ST_SWEEP) ? pos_ff[AW-1:0] : '0;
   assign mem_we  = req_fire && (req_payload.kind == dsm_pkg::KIND_APPEND) &&
                    (len_ff < LW'(MAX_PATTERN));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         pattern_mem[len_ff[AW-1:0]] <= req_payload.symbol;
      end
      rd_data_ff <= pattern_mem[rd_addr];
   end

   // The one evaluation unit serves both the sweep over a text character and the
   // empty-text bit of a newly appended character. For the latter both old-row
   // bits are zero, so only a star can set it, through the bit two positions back.
   always_comb begin
      if (state_ff == ST_SWEEP) begin
         cell_in.pat_char  = rd_data_ff;
         cell_in.prev_char = prev_char_ff;
         cell_in.text_char = sym_ff;
         cell_in.first_pos = (pos_ff == LW'(1));
         cell_in.old_jm1   = old_prev_ff;
         cell_in.old_j     = row_ff[pos_ff];
         cell_in.new_jm2   = new2_ff;
      end else begin
         cell_in.pat_char  = req_payload.symbol;
         cell_in.prev_char = '0;
         cell_in.text_char = '0;
         cell_in.first_pos = (len_ff == '0);
         cell_in.old_jm1   = 1'b0;
         cell_in.old_j     = 1'b0;
         cell_in.new_jm2   = (len_ff != '0) ? empty_ff[len_ff - LW'(1)] : 1'b0;
      end
   end

   dsm_cell_unit u_cell (
      .cell_in  (cell_in),
      .next_bit (cell_next)
   );

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      len_in       = len_ff;
      ovf_in       = ovf_ff;
      empty_in     = empty_ff;
      row_in       = row_ff;
      old_prev_in  = old_prev_ff;
      new1_in      = new1_ff;
      new2_in      = new2_ff;
      prev_char_in = prev_char_ff;
      sym_in       = sym_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_payload.kind)
                  dsm_pkg::KIND_CLEAR: begin
                     len_in   = '0;
                     ovf_in   = 1'b0;
                     empty_in = ROW'(1);
                     row_in   = ROW'(1);
                  end
                  dsm_pkg::KIND_APPEND: begin
                     // Appending restarts any text in progress.
                     if (len_ff < LW'(MAX_PATTERN)) begin
                        len_in = len_plus;
                        empty_in[len_plus] = cell_next;
                        row_in = empty_in;
                     end else begin
                        ovf_in = 1'b1;
                        row_in = empty_ff;
                     end
                  end
                  dsm_pkg::KIND_TEXT: begin
                     // Bit zero never survives a character; the sweep fills 1..L.
                     row_in[0]   = 1'b0;
                     old_prev_in = row_ff[0];
                     new1_in     = 1'b0;
                     sym_in      = req_payload.symbol;
                     pos_in      = LW'(1);
                     if (len_ff != '0) begin
                        state_in = ST_SWEEP;
                     end
                  end
                  dsm_pkg::KIND_END: begin
                     rsp_valid_in                 = 1'b1;
                     rsp_data_in.matched          = row_ff[len_ff];
                     rsp_data_in.pattern_overflow = ovf_ff;
                     row_in                       = empty_ff;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            row_in[pos_ff] = cell_next;
            old_prev_in    = row_ff[pos_ff];
            new2_in        = new1_ff;
            new1_in        = cell_next;
            prev_char_in   = rd_data_ff;
            pos_in         = pos_ff + LW'(1);
            if (pos_ff == len_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         empty_ff     <= ROW'(1);
         row_ff       <= ROW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         ovf_ff       <= ovf_in;
         empty_ff     <= empty_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff       <= pos_in;
      old_prev_ff  <= old_prev_in;
      new1_ff      <= new1_in;
      new2_ff      <= new2_in;
      prev_char_ff <= prev_char_in;
      sym_ff       <= sym_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // The sweep never visits a position outside the stored pattern.
   a_sweep_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> ((pos_ff >= LW'(1)) && (pos_ff <= len_ff)))
      else $error("sweep position outside stored pattern");

   // The stored length never exceeds the pattern capacity.
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LW'(MAX_PATTERN))
      else $error("pattern length beyond capacity");

   // A new result appears only right after an end-of-text transfer.
   a_rsp_from_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && !rsp_ready)) |->
      $past(req_fire && (req_payload.kind == dsm_pkg::KIND_END)))
      else $error("result without end-of-text transfer");

   // The empty pattern always matches the empty text.
   a_empty_bit0: assert property (@(posedge clock) disable iff (reset)
      empty_ff[0])
      else $error("empty-text row lost bit zero");

endmodule
